[rtl/dcs_pkg.sv]
package dcs_pkg;

  localparam int unsigned LineBits   = 16;
  localparam int unsigned StartLineW = 16;
  localparam logic [LineBits-1:0] LineMax = {LineBits{1'b1}};

  localparam int unsigned QueueDepth = 3;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic       ModeData  = 1'b0;
  localparam logic       ModeFlush = 1'b1;

  localparam logic [1:0] SepModeReset = 2'd1;

  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChSemi  = 8'h3b;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChBsl   = 8'h5c;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChSq    = 8'h27;
  localparam logic [7:0] ChDq    = 8'h22;

  typedef enum logic {
    KindChar = 1'b0,
    KindEnd  = 1'b1
  } kind_e;

  typedef struct packed {
    logic                skip_comment;
    logic                at_line_start;
    logic                in_single_quote;
    logic                in_double_quote;
    logic                escape_pending;
    logic                line_indented;
    logic                command_nonempty;
    logic [LineBits-1:0] newline_count;
    logic [LineBits-1:0] command_line;
  } state_t;

  typedef struct packed {
    kind_e                 kind;
    logic [7:0]            char_value;
    logic [StartLineW-1:0] start_line;
    logic                  last;
  } result_t;

  localparam state_t StateReset = '{
    skip_comment:     1'b0,
    at_line_start:    1'b1,
    in_single_quote:  1'b0,
    in_double_quote:  1'b0,
    escape_pending:   1'b0,
    line_indented:    1'b0,
    command_nonempty: 1'b0,
    newline_count:    '0,
    command_line:     '0
  };

endpackage

[rtl/dcs_parser.sv]
module dcs_parser (
  input  dcs_pkg::state_t        state_i,
  input  logic [1:0]             sep_mode_i,
  input  logic                   mode_i,
  input  logic [7:0]             byte_i,
  output dcs_pkg::state_t        state_o,
  output logic [1:0]             count_o,
  output dcs_pkg::result_t [1:0] res_o
);

  function automatic dcs_pkg::state_t clear_flags(dcs_pkg::state_t s);
    dcs_pkg::state_t r;
    r                 = s;
    r.skip_comment    = 1'b0;
    r.at_line_start   = 1'b1;
    r.in_single_quote = 1'b0;
    r.in_double_quote = 1'b0;
    r.escape_pending  = 1'b0;
    r.line_indented   = 1'b0;
    return r;
  endfunction

  function automatic dcs_pkg::result_t mk_res(dcs_pkg::kind_e k, logic [7:0] ch,
                                              logic [dcs_pkg::LineBits-1:0] line);
    dcs_pkg::result_t r;
    r.kind       = k;
    r.char_value = ch;
    r.start_line = dcs_pkg::StartLineW'(line);
    r.last       = 1'b0;
    return r;
  endfunction

  always_comb begin
    dcs_pkg::state_t        s;
    dcs_pkg::result_t [1:0] res;
    logic [1:0]             n;
    logic                   blank;
    logic                   is_lf;
    logic                   e_bs;
    logic                   e_ch;

    s     = state_i;
    res   = '0;
    n     = 2'd0;
    e_bs  = 1'b0;
    e_ch  = 1'b0;
    blank = (byte_i == dcs_pkg::ChSpace) || (byte_i == dcs_pkg::ChTab);
    is_lf = (byte_i == dcs_pkg::ChLf);

    if (mode_i == dcs_pkg::ModeFlush) begin
      if (s.command_nonempty) begin
        res[0] = mk_res(dcs_pkg::KindEnd, 8'd0, s.command_line);
        n      = 2'd1;
      end
      s = dcs_pkg::StateReset;
    end else if (byte_i != dcs_pkg::ChCr) begin
      if (is_lf && (s.newline_count != dcs_pkg::LineMax)) begin
        s.newline_count = s.newline_count + 1'b1;
      end
      if (blank && s.at_line_start) begin
        s.line_indented = 1'b1;
      end
      if (!s.at_line_start || (!blank && !is_lf)) begin
        if (s.at_line_start) begin
          if (sep_mode_i[1] && !s.line_indented && s.command_nonempty) begin
            res[n[0]]          = mk_res(dcs_pkg::KindEnd, 8'd0, s.command_line);
            n                  = n + 2'd1;
            s.command_nonempty = 1'b0;
            s                  = clear_flags(s);
          end
          if (byte_i == dcs_pkg::ChHash) begin
            s.skip_comment = 1'b1;
          end
          s.at_line_start = 1'b0;
        end
        if (is_lf) begin
          s.line_indented = 1'b0;
          s.at_line_start = 1'b1;
        end
        if (is_lf && s.skip_comment) begin
          s.skip_comment = 1'b0;
        end else if (!s.skip_comment) begin
          if ((byte_i == dcs_pkg::ChBsl) && (s.in_single_quote || s.in_double_quote)
              && !s.escape_pending) begin
            s.escape_pending = 1'b1;
          end else begin
            if ((byte_i == dcs_pkg::ChSq) && !s.in_double_quote && !s.escape_pending) begin
              s.in_single_quote = !s.in_single_quote;
            end
            if ((byte_i == dcs_pkg::ChDq) && !s.in_single_quote && !s.escape_pending) begin
              s.in_double_quote = !s.in_double_quote;
            end
            if ((byte_i == dcs_pkg::ChSemi) && sep_mode_i[0] && !s.in_single_quote
                && !s.in_double_quote) begin
              if (s.command_nonempty) begin
                res[n[0]] = mk_res(dcs_pkg::KindEnd, 8'd0, s.command_line);
                n         = n + 2'd1;
              end
              s.command_nonempty = 1'b0;
              s                  = clear_flags(s);
            end else begin
              e_bs             = s.escape_pending;
              e_ch             = 1'b1;
              s.escape_pending = 1'b0;
            end
          end
        end
      end
    end

    if (e_ch && !s.command_nonempty) begin
      s.command_line     = (s.newline_count == dcs_pkg::LineMax) ? dcs_pkg::LineMax
                                                                 : s.newline_count + 1'b1;
      s.command_nonempty = 1'b1;
    end
    if (e_bs) begin
      res[n[0]] = mk_res(dcs_pkg::KindChar, dcs_pkg::ChBsl, s.command_line);
      n         = n + 2'd1;
    end
    if (e_ch) begin
      res[n[0]] = mk_res(dcs_pkg::KindChar, byte_i, s.command_line);
      n         = n + 2'd1;
    end

    if (n == 2'd1) begin
      res[0].last = 1'b1;
    end else if (n == 2'd2) begin
      res[1].last = 1'b1;
    end

    state_o = s;
    count_o = n;
    res_o   = res;
  end

endmodule

[rtl/descriptor_command_splitter_core.sv]
// Splits a descriptor byte stream into command texts: one byte is taken per cycle into an
// input register, its flag and line-counter update is worked out while it is held there and its
// zero to two results go into a three-entry output queue that delivers one result per cycle
// while stall_i is low. A new byte is taken every cycle while the queue has room for the
// results of the byte held; bytes that yield two results (escaped characters, a break on a
// non-indented line) can stall the input while the output drains one result per cycle.
// A byte's results pass the input register and the output queue before they are presented.
// cfg_data_i sets the separator mode (bit 0: unquoted ';' ends a command, bit 1: a
// non-indented line ends a command) and must be written only while no item is in flight.
module descriptor_command_splitter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_data_i,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        mode_i,
  input  logic [7:0]  byte_value_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic        kind_o,
  output logic [7:0]  char_value_o,
  output logic [15:0] start_line_o,
  output logic        last_o
);

  function automatic logic [dcs_pkg::QPtrW-1:0] ptr_inc(logic [dcs_pkg::QPtrW-1:0] p);
    return (p == dcs_pkg::QPtrW'(dcs_pkg::QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [1:0]             sep_mode_q;
  logic                   in_v_q;
  logic                   in_mode_q;
  logic [7:0]             in_byte_q;
  dcs_pkg::state_t        st_q, st_d;
  logic [1:0]             n_res;
  dcs_pkg::result_t [1:0] res;

  dcs_pkg::result_t            q_mem [dcs_pkg::QueueDepth];
  logic [dcs_pkg::QPtrW-1:0]   rd_q, rd_d, wr_q, wr_d;
  logic [dcs_pkg::QCntW-1:0]   cnt_q, cnt_d;
  logic [dcs_pkg::QCntW-1:0]   q_free;
  logic                        adv;
  logic                        pop;

  dcs_parser u_parser (
    .state_i    (st_q),
    .sep_mode_i (sep_mode_q),
    .mode_i     (in_mode_q),
    .byte_i     (in_byte_q),
    .state_o    (st_d),
    .count_o    (n_res),
    .res_o      (res)
  );

  assign q_free  = dcs_pkg::QCntW'(dcs_pkg::QueueDepth) - cnt_q;
  assign adv     = in_v_q && (dcs_pkg::QCntW'(n_res) <= q_free);
  assign stall_o = in_v_q && !adv;
  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && !stall_i;

  always_comb begin
    wr_d = wr_q;
    if (adv && (n_res == 2'd1)) begin
      wr_d = ptr_inc(wr_q);
    end else if (adv && (n_res == 2'd2)) begin
      wr_d = ptr_inc(ptr_inc(wr_q));
    end
    rd_d  = pop ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q + (adv ? dcs_pkg::QCntW'(n_res) : '0) - dcs_pkg::QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_mode_q <= dcs_pkg::SepModeReset;
      in_v_q     <= 1'b0;
      st_q       <= dcs_pkg::StateReset;
      rd_q       <= '0;
      wr_q       <= '0;
      cnt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        sep_mode_q <= cfg_data_i;
      end
      if (!stall_o) begin
        in_v_q <= valid_i;
      end
      if (adv) begin
        st_q <= st_d;
      end
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      in_mode_q <= mode_i;
      in_byte_q <= byte_value_i;
    end
    if (adv && (n_res != 2'd0)) begin
      q_mem[wr_q] <= res[0];
    end
    if (adv && (n_res == 2'd2)) begin
      q_mem[ptr_inc(wr_q)] <= res[1];
    end
  end

  assign kind_o       = q_mem[rd_q].kind;
  assign char_value_o = q_mem[rd_q].char_value;
  assign start_line_o = q_mem[rd_q].start_line;
  assign last_o       = q_mem[rd_q].last;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= dcs_pkg::QCntW'(dcs_pkg::QueueDepth))
    else $error("output queue overfilled");

  a_res_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (n_res != 2'd0)) |=> valid_o)
    else $error("result pushed but not presented");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (in_mode_q == dcs_pkg::ModeFlush)) |=>
      (!st_q.command_nonempty && (st_q.newline_count == '0) && st_q.at_line_start))
    else $error("end of stream did not reset state");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(st_q))
    else $error("state changed without an item");

endmodule
